[sv/xlb_pkg.sv]
package xlb_pkg;

	localparam int unsigned VEC_WIDTH_DEF = 31;
	localparam int unsigned VAL_W         = 31;
	localparam int unsigned RANK_W        = 5;

	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_REDUCE = 2'd1;
	localparam logic [1:0] REQ_QUERY  = 2'd2;
	localparam logic [1:0] REQ_NOP    = 2'd3;

	typedef struct packed {
		logic [1:0]       req_type;
		logic [VAL_W-1:0] vector_value;
		logic             maximize;
	} req_t;

	typedef struct packed {
		logic [VAL_W-1:0]  query_result;
		logic              was_added;
		logic [RANK_W-1:0] basis_rank;
	} rsp_t;

	typedef struct packed {
		logic       load;
		logic       step;
		logic       commit;
		logic [1:0] op;
		logic       maximize;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN
	} ctl_state_t;

endpackage

[sv/xor_linear_basis_top.sv]
// Channel   Valid      Stall      Payload
// request   req_valid  req_stall  req (xlb_pkg::req_t)
// response  rsp_valid  rsp_stall  rsp (xlb_pkg::rsp_t)
//
// Every request passes through a load of the cell row, VEC_WIDTH shift steps
// through the row of pivot cells and a write of the response register.
// One request is in the row at a time; req_stall stays high after the load until
// the response is written. The next request is taken while a response waits.
// Reset clears all pivot slots and the rank at once; no clearing pass.
// A stalled response holds the row after its last step until the register frees.
module xor_linear_basis_top #(
	parameter int unsigned VEC_WIDTH = xlb_pkg::VEC_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  xlb_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output xlb_pkg::rsp_t rsp
);
	import xlb_pkg::*;

	localparam int unsigned RW = $clog2(VEC_WIDTH + 1);

	cell_ctl_t            ctl;
	logic                 rsp_free;
	logic [VEC_WIDTH-1:0] item_vec;
	logic [VEC_WIDTH-1:0] c_vec [VEC_WIDTH];
	logic [VEC_WIDTH-1:0] c_live;
	logic [VEC_WIDTH-1:0] store_w;
	logic [RW-1:0]        rank_q;
	logic [VAL_W-1:0]     res_val;
	logic [RANK_W-1:0]    rank_out;
	logic                 rsp_valid_q;
	rsp_t                 rsp_q;

	generate
		if (VEC_WIDTH == VAL_W) begin : g_same
			assign item_vec = req.vector_value;
			assign res_val  = c_vec[0];
		end else if (VEC_WIDTH < VAL_W) begin : g_narrow
			assign item_vec = req.vector_value[VEC_WIDTH-1:0];
			assign res_val  = {{(VAL_W - VEC_WIDTH){1'b0}}, c_vec[0]};
		end else begin : g_wide
			assign item_vec = {{(VEC_WIDTH - VAL_W){1'b0}}, req.vector_value};
			assign res_val  = c_vec[0][VAL_W-1:0];
		end
		if (RW >= RANK_W) begin : g_rank_cut
			assign rank_out = rank_q[RANK_W-1:0];
		end else begin : g_rank_ext
			assign rank_out = {{(RANK_W - RW){1'b0}}, rank_q};
		end
	endgenerate

	assign rsp_free = !rsp_valid_q || !rsp_stall;

	xlb_ctrl #(
		.VEC_WIDTH(VEC_WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req      (req),
		.req_stall(req_stall),
		.rsp_free (rsp_free),
		.ctl      (ctl)
	);

	genvar g;
	generate
		for (g = 0; g < VEC_WIDTH; g++) begin : g_cell
			logic [VEC_WIDTH-1:0] nb_vec;
			logic                 nb_live;
			if (g == VEC_WIDTH - 1) begin : g_wrap
				assign nb_vec  = c_vec[0];
				assign nb_live = c_live[0] && (ctl.op != REQ_REDUCE);
			end else begin : g_link
				assign nb_vec  = c_vec[g+1];
				assign nb_live = c_live[g+1];
			end
			xlb_cell #(
				.VEC_WIDTH(VEC_WIDTH),
				.IDX      (g)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctl     (ctl),
				.item_vec(item_vec),
				.in_vec  (nb_vec),
				.in_live (nb_live),
				.vec     (c_vec[g]),
				.live    (c_live[g]),
				.store   (store_w[g])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q <= '0;
		end else if (|store_w) begin
			rank_q <= rank_q + RW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctl.commit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			rsp_q.query_result <= (ctl.op == REQ_QUERY) ? res_val : '0;
			rsp_q.was_added    <= (ctl.op == REQ_INSERT) && !c_live[0];
			rsp_q.basis_rank   <= rank_out;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_one_store: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(store_w))
		else $error("more than one pivot slot written in a cycle");

	a_store_insert: assert property (@(posedge clk) disable iff (!arst_n)
		|store_w |-> (ctl.step && ctl.op == REQ_INSERT))
		else $error("pivot slot written outside an insert walk");

	a_rank_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rank_q <= RW'(VEC_WIDTH))
		else $error("rank above vector width");

	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.step || ctl.commit) |-> req_stall)
		else $error("request taken while the row is busy");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit |-> !(rsp_valid_q && rsp_stall))
		else $error("response register overwritten while stalled");

endmodule

[sv/xlb_cell.sv]
module xlb_cell #(
	parameter int unsigned VEC_WIDTH = xlb_pkg::VEC_WIDTH_DEF,
	parameter int unsigned IDX       = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  xlb_pkg::cell_ctl_t    ctl,
	input  logic [VEC_WIDTH-1:0]  item_vec,
	input  logic [VEC_WIDTH-1:0]  in_vec,
	input  logic                  in_live,
	output logic [VEC_WIDTH-1:0]  vec,
	output logic                  live,
	output logic                  store
);
	import xlb_pkg::*;

	logic [VEC_WIDTH-1:0] slot_q;
	logic [VEC_WIDTH-1:0] c_vec_q;
	logic                 c_live_q;
	logic [VEC_WIDTH-1:0] nxt_vec;
	logic                 nxt_live;
	logic                 store_hit;
	logic                 hit;
	logic                 occ;

	assign hit = in_vec[IDX];
	assign occ = |slot_q;

	always_comb begin
		nxt_vec   = in_vec;
		nxt_live  = in_live;
		store_hit = 1'b0;
		unique case (ctl.op)
			REQ_INSERT: begin
				if (in_live && hit) begin
					if (!occ) begin
						store_hit = 1'b1;
						nxt_live  = 1'b0;
					end else begin
						nxt_vec = in_vec ^ slot_q;
					end
				end
			end
			REQ_REDUCE: begin
				if (in_live && hit && occ) begin
					nxt_vec = in_vec ^ slot_q;
				end
			end
			REQ_QUERY: begin
				if (occ && (ctl.maximize ? !hit : hit)) begin
					nxt_vec = in_vec ^ slot_q;
				end
			end
			default: begin
				nxt_vec = in_vec;
			end
		endcase
	end

	assign store = ctl.step && store_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (store) begin
			slot_q <= in_vec;
		end else if (ctl.commit && ctl.op == REQ_REDUCE) begin
			slot_q <= c_vec_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_live_q <= 1'b0;
		end else if (ctl.load) begin
			c_live_q <= (ctl.op == REQ_REDUCE) || (IDX == 0);
		end else if (ctl.step) begin
			c_live_q <= nxt_live;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			if (ctl.op == REQ_REDUCE) begin
				c_vec_q <= slot_q;
			end else if (IDX == 0) begin
				c_vec_q <= item_vec;
			end else begin
				c_vec_q <= '0;
			end
		end else if (ctl.step) begin
			c_vec_q <= nxt_vec;
		end
	end

	assign vec  = c_vec_q;
	assign live = c_live_q;

endmodule

[sv/xlb_ctrl.sv]
module xlb_ctrl #(
	parameter int unsigned VEC_WIDTH = xlb_pkg::VEC_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  xlb_pkg::req_t      req,
	output logic               req_stall,
	input  logic               rsp_free,
	output xlb_pkg::cell_ctl_t ctl
);
	import xlb_pkg::*;

	localparam int unsigned CW = $clog2(VEC_WIDTH + 1);

	ctl_state_t    state_q;
	ctl_state_t    state_nxt;
	logic [CW-1:0] cnt_q;
	logic [1:0]    op_q;
	logic          max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt    = state_q;
		req_stall    = 1'b1;
		ctl.load     = 1'b0;
		ctl.step     = 1'b0;
		ctl.commit   = 1'b0;
		ctl.op       = op_q;
		ctl.maximize = max_q;
		unique case (state_q)
			ST_IDLE: begin
				req_stall    = 1'b0;
				ctl.op       = req.req_type;
				ctl.maximize = req.maximize;
				if (req_valid) begin
					ctl.load  = 1'b1;
					state_nxt = ST_RUN;
				end
			end
			ST_RUN: begin
				ctl.step = 1'b1;
				if (cnt_q == CW'(VEC_WIDTH - 1)) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (rsp_free) begin
					ctl.commit = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			op_q  <= REQ_NOP;
			max_q <= 1'b0;
		end else if (ctl.load) begin
			cnt_q <= '0;
			op_q  <= req.req_type;
			max_q <= req.maximize;
		end else if (ctl.step) begin
			cnt_q <= cnt_q + CW'(1);
		end
	end

endmodule

[bench/tb_xor_linear_basis_top.sv]
`timescale 1ns / 100ps

module tb_xor_linear_basis_top;
	import xlb_pkg::*;

	localparam int unsigned VW            = VEC_WIDTH_DEF;
	localparam int unsigned CYCLE_LIMIT   = 600000;
	localparam int unsigned SETTLE_CYCLES = VW + 8;
	localparam int unsigned PHASE_ITEMS   = 330;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	logic [VAL_W-1:0] pivot_rows [VW];
	int unsigned      span_rank;
	rsp_t             pending_rsps [$];
	logic [VAL_W-1:0] span_pool [$];

	int unsigned send_idle_pct = 0;
	int unsigned rsp_stall_pct = 0;
	int unsigned errors        = 0;
	int unsigned cycle_count   = 0;
	int unsigned n_req         = 0;
	int unsigned n_stored      = 0;
	int unsigned n_dependent   = 0;
	int unsigned n_query       = 0;
	int unsigned n_reduce      = 0;
	int unsigned n_nop         = 0;

	xor_linear_basis_top #(
		.VEC_WIDTH(VW)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
	end

	function automatic rsp_t predict_rsp(req_t r);
		rsp_t             res;
		logic [VAL_W-1:0] v;
		logic             done;
		res  = '0;
		v    = r.vector_value;
		done = 1'b0;
		case (r.req_type)
		REQ_INSERT: begin
			for (int i = VW - 1; i >= 0; i--) begin
				if (!done && v[i]) begin
					if (pivot_rows[i] == '0) begin
						pivot_rows[i] = v;
						span_rank++;
						res.was_added = 1'b1;
						done = 1'b1;
					end else begin
						v ^= pivot_rows[i];
					end
				end
			end
		end
		REQ_REDUCE: begin
			for (int i = 0; i < VW; i++) begin
				if (pivot_rows[i] != '0) begin
					for (int j = i + 1; j < VW; j++) begin
						if (pivot_rows[j][i])
							pivot_rows[j] ^= pivot_rows[i];
					end
				end
			end
		end
		REQ_QUERY: begin
			for (int i = VW - 1; i >= 0; i--) begin
				if (pivot_rows[i] != '0 && v[i] != r.maximize)
					v ^= pivot_rows[i];
			end
			res.query_result = v;
		end
		default: begin
		end
		endcase
		res.basis_rank = RANK_W'(span_rank);
		return res;
	endfunction

	function automatic req_t random_req();
		req_t             r;
		int unsigned      pick;
		logic [VAL_W-1:0] v;
		r.req_type     = REQ_QUERY;
		r.vector_value = VAL_W'($urandom);
		r.maximize     = 1'($urandom_range(1));
		pick           = $urandom_range(99);
		if (pick < 45) begin
			r.req_type = REQ_INSERT;
			if ($urandom_range(99) < 6 || span_pool.size() == 0) begin
				v = VAL_W'($urandom) >> $urandom_range(VAL_W - 1);
				span_pool.insert(span_pool.size(), v);
			end else begin
				v = '0;
				foreach (span_pool[k]) begin
					if ($urandom_range(1))
						v ^= span_pool[k];
				end
			end
			r.vector_value = v;
		end else if (pick < 55) begin
			r.req_type = REQ_REDUCE;
		end else if (pick < 62) begin
			r.req_type = REQ_NOP;
		end
		return r;
	endfunction

	task automatic send_req(req_t r);
		rsp_t want;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		want = predict_rsp(r);
		pending_rsps.insert(pending_rsps.size(), want);
		n_req++;
		case (r.req_type)
		REQ_INSERT: begin
			if (want.was_added)
				n_stored++;
			else
				n_dependent++;
		end
		REQ_REDUCE: n_reduce++;
		REQ_QUERY:  n_query++;
		default:    n_nop++;
		endcase
	endtask

	task automatic send_op(logic [1:0] op, logic [VAL_W-1:0] value, logic maxi);
		req_t r;
		r.req_type     = op;
		r.vector_value = value;
		r.maximize     = maxi;
		if (op == REQ_INSERT)
			span_pool.insert(span_pool.size(), value);
		send_req(r);
	endtask

	task automatic drain_rsps();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_rsps.size() != 0);
	endtask

	task automatic run_random(int unsigned count);
		repeat (count)
			send_req(random_req());
	endtask

	task automatic test_directed();
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		send_op(REQ_QUERY,  31'h2AAAAAAA, 1'b0);
		send_op(REQ_QUERY,  31'h55555555, 1'b1);
		send_op(REQ_NOP,    31'h7FFFFFFF, 1'b1);
		send_op(REQ_INSERT, 31'h00000000, 1'b0);
		send_op(REQ_INSERT, 31'h7FFFFFFF, 1'b0);
		send_op(REQ_INSERT, 31'h7FFFFFFF, 1'b1);
		send_op(REQ_INSERT, 31'h00000001, 1'b0);
		send_op(REQ_INSERT, 31'h40000000, 1'b0);
		send_op(REQ_INSERT, 31'h3FFFFFFF, 1'b0);
		send_op(REQ_INSERT, 31'h00010000, 1'b0);
		send_op(REQ_INSERT, 31'h00018001, 1'b0);
		send_op(REQ_QUERY,  31'h7FFFFFFF, 1'b0);
		send_op(REQ_QUERY,  31'h00000000, 1'b1);
		send_op(REQ_REDUCE, 31'h7FFFFFFF, 1'b1);
		send_op(REQ_QUERY,  31'h7FFFFFFF, 1'b0);
		send_op(REQ_QUERY,  31'h12345678, 1'b1);
		send_op(REQ_INSERT, 31'h40000001, 1'b0);
		send_op(REQ_NOP,    31'h00000000, 1'b0);
		send_op(REQ_REDUCE, 31'h00000000, 1'b0);
		send_op(REQ_QUERY,  31'h00000000, 1'b0);
	endtask

	task automatic test_back_to_back();
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		run_random(PHASE_ITEMS);
	endtask

	task automatic test_sender_gaps();
		send_idle_pct = 70;
		rsp_stall_pct = 0;
		run_random(PHASE_ITEMS);
	endtask

	task automatic test_receiver_stalls();
		send_idle_pct = 0;
		rsp_stall_pct = 70;
		run_random(PHASE_ITEMS);
	endtask

	task automatic test_mixed_idle();
		send_idle_pct = 12;
		rsp_stall_pct = 12;
		run_random(PHASE_ITEMS);
	endtask

	task automatic test_drain_pause();
		send_idle_pct = 0;
		rsp_stall_pct = 30;
		repeat (6) begin
			repeat ($urandom_range(5, 1))
				send_req(random_req());
			drain_rsps();
		end
	endtask

	always @(posedge clk) begin : check_rsp
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsps.size() == 0) begin
				$error("response with no request outstanding: %h", rsp);
				errors++;
			end else begin
				want = pending_rsps.pop_front();
				if (rsp.query_result !== want.query_result) begin
					$error("query_result expected %h got %h", want.query_result,
						rsp.query_result);
					errors++;
				end
				if (rsp.was_added !== want.was_added) begin
					$error("was_added expected %b got %b", want.was_added, rsp.was_added);
					errors++;
				end
				if (rsp.basis_rank !== want.basis_rank) begin
					$error("basis_rank expected %0d got %0d", want.basis_rank,
						rsp.basis_rank);
					errors++;
				end
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$error("timeout after %0d cycles, %0d responses outstanding", cycle_count,
			pending_rsps.size());
		$display("tb_xor_linear_basis_top failed");
		$finish;
	end

	initial begin
		foreach (pivot_rows[i])
			pivot_rows[i] = '0;
		span_rank = 0;
		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_back_to_back();
		test_sender_gaps();
		test_drain_pause();
		test_receiver_stalls();
		test_mixed_idle();
		drain_rsps();
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		if (pending_rsps.size() != 0) begin
			$error("%0d responses never arrived", pending_rsps.size());
			errors++;
		end
		$display("%0d requests: %0d inserts stored, %0d dependent, %0d queries,",
			n_req, n_stored, n_dependent, n_query);
		$display("%0d reduces, %0d no-ops; idle mixes none/sender/receiver/both, drain pauses;",
			n_reduce, n_nop);
		$display("final rank %0d, %0d errors", span_rank, errors);
		if (errors == 0)
			$display("tb_xor_linear_basis_top passed");
		else
			$display("tb_xor_linear_basis_top failed");
		$finish;
	end

endmodule

[filelist.f]
sv/xlb_pkg.sv
sv/xlb_cell.sv
sv/xlb_ctrl.sv
sv/xor_linear_basis_top.sv
bench/tb_xor_linear_basis_top.sv
